FILE: rtl/rte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_pkg: shared types and constants of the IPv4 route table engine
// Operation codes, status codes, register indexes and word types.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXISTS  = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_UNREACH = 2'd3;

    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_BCAST      = 2'd0;
    localparam logic [1:0]  CFG_LL_GATEWAY = 2'd1;
    localparam logic [1:0]  CFG_LL_MATCH   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  device_id;
        logic [31:0] iface_addr;
        logic [31:0] gateway_address;
        logic [31:0] destination_address;
        logic [31:0] subnet_mask;
        logic [7:0]  route_flags;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_device_id;
        logic [31:0] out_iface_addr;
        logic [31:0] out_gateway_address;
        logic [31:0] out_subnet_mask;
    } rsp_word_t;

    // one stored route (flags kept but never read back)
    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] iface;
        logic [31:0] gateway;
        logic [31:0] destination;
        logic [31:0] mask;
        logic [7:0]  flags;
    } route_t;

endpackage

FILE: rtl/rte_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface rte_req_if;
    logic                valid;
    logic                ready;
    rte_pkg::req_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rte_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_rsp_if: response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface rte_rsp_if;
    logic                valid;
    logic                ready;
    rte_pkg::rsp_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ipv4_route_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_table_engine: route table with add, remove and lookup
// Route entries live in one synchronous memory scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Each request word walks the whole route memory through its single read port,
// one entry per cycle with a registered read; remove clears the valid bit of
// each matching entry during the walk, and add writes the new route into the
// memory and sets its valid bit after the walk.
// One request is in work at a time; the next is taken once the response word
// has been loaded into the output register. Valid bits are flip-flops cleared
// by reset, so no clearing pass is needed.
module ipv4_route_table_engine #(
    parameter int ROUTE_ENTRIES = rte_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rte_req_if.sink                       req,
    rte_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(ROUTE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // configuration registers
    logic [31:0] bcast_reg, llgw_reg, llmatch_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcast_reg   <= 32'hFFFF_FFFF;
            llgw_reg    <= 32'h0;
            llmatch_reg <= 32'hFFFF_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rte_pkg::CFG_BCAST:      bcast_reg   <= cfg_data;
                rte_pkg::CFG_LL_GATEWAY: llgw_reg    <= cfg_data;
                rte_pkg::CFG_LL_MATCH:   llmatch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // route memory and valid bits
    rte_pkg::route_t mem [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] valid_reg;
    rte_pkg::route_t rd_q;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    rte_pkg::route_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // control
    logic [1:0]         state_reg;
    logic [CW-1:0]      cnt_reg;      // address issued
    logic               rv_reg;       // rd_q holds entry ridx_reg
    logic [IW-1:0]      ridx_reg;
    rte_pkg::req_word_t q_reg;
    logic               exists_reg, free_ok_reg, best_ok_reg, dflt_ok_reg;
    logic [IW-1:0]      free_reg;
    logic [31:0]        score_reg, bmask_reg;
    rte_pkg::route_t    best_reg, dflt_reg;
    rte_pkg::rsp_word_t out_reg;
    logic               ovalid_reg;

    assign rd_addr   = cnt_reg[IW-1:0];
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = out_reg;

    // per-entry evaluation of the word read last cycle
    logic        ent_v, dev_ok, is_bcast, ifa0, ll_hit, dflt_hit, m_hit, s_win;
    logic [31:0] s;
    always_comb
    begin
        ent_v    = rv_reg && valid_reg[ridx_reg];
        dev_ok   = (q_reg.device_id == 8'd0) || (rd_q.device == q_reg.device_id);
        is_bcast = (q_reg.destination_address == bcast_reg);
        ifa0     = (q_reg.iface_addr == 32'd0);
        s        = q_reg.destination_address & rd_q.mask;
        ll_hit   = ent_v && dev_ok && (ifa0 || rd_q.iface == q_reg.iface_addr)
                   && is_bcast && (rd_q.gateway == llgw_reg);
        dflt_hit = !ll_hit && ent_v && dev_ok && ifa0 && !is_bcast
                   && (rd_q.mask == 32'd0);
        m_hit    = !ll_hit && !dflt_hit && ent_v && dev_ok && ifa0
                   && (s == (rd_q.destination & rd_q.mask));
        s_win    = m_hit && (s != 32'd0) && ((s > score_reg) ||
                   ((s == score_reg) && best_ok_reg && (rd_q.mask > bmask_reg)));
    end

    logic dup, rm_hit;
    assign dup = ent_v && (rd_q.iface == q_reg.iface_addr)
                 && (rd_q.gateway == q_reg.gateway_address)
                 && (rd_q.destination == q_reg.destination_address)
                 && (rd_q.mask == q_reg.subnet_mask);
    assign rm_hit = ent_v
                 && (q_reg.device_id == 8'd0 || rd_q.device == q_reg.device_id)
                 && (q_reg.gateway_address == 32'd0
                     || rd_q.gateway == q_reg.gateway_address)
                 && (q_reg.destination_address == 32'd0
                     || rd_q.destination == q_reg.destination_address);

    // add writes at the end of the walk
    logic do_add;
    assign do_add  = (state_reg == S_DONE) && (q_reg.operation == rte_pkg::OP_ADD)
                     && !exists_reg && free_ok_reg;
    assign wr_en   = do_add;
    assign wr_addr = free_reg;
    assign wr_data = '{device: q_reg.device_id, iface: q_reg.iface_addr,
                       gateway: q_reg.gateway_address,
                       destination: q_reg.destination_address,
                       mask: q_reg.subnet_mask, flags: q_reg.route_flags};

    // response word built from the scan results
    rte_pkg::rsp_word_t res;
    rte_pkg::route_t    pick;
    always_comb
    begin
        res  = '0;
        pick = best_ok_reg ? best_reg : dflt_reg;
        unique case (q_reg.operation)
            rte_pkg::OP_ADD:
                res.status = exists_reg ? rte_pkg::ST_EXISTS
                           : (free_ok_reg ? rte_pkg::ST_OK : rte_pkg::ST_NOMEM);
            rte_pkg::OP_LOOKUP:
            begin
                if (!best_ok_reg && !dflt_ok_reg)
                begin
                    res.status         = rte_pkg::ST_UNREACH;
                    res.out_device_id  = q_reg.device_id;
                    res.out_iface_addr = q_reg.iface_addr;
                end
                else
                begin
                    res.status = rte_pkg::ST_OK;
                    res.out_device_id = (q_reg.device_id == 8'd0) ? pick.device
                                                                  : q_reg.device_id;
                    res.out_iface_addr = ifa0 ? pick.iface : q_reg.iface_addr;
                    res.out_gateway_address =
                        (best_ok_reg && pick.gateway == llgw_reg)
                        ? q_reg.destination_address : pick.gateway;
                    res.out_subnet_mask = pick.mask;
                end
            end
            default: ;
        endcase
    end

    // output register takes a new word when empty or being drained
    logic load_out;
    assign load_out = (state_reg == S_OUT) && (!ovalid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rv_reg     <= 1'b0;
            ridx_reg   <= '0;
            valid_reg  <= '0;
            out_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_reg    <= res;
                ovalid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        rv_reg    <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    rv_reg   <= (cnt_reg <= LAST);
                    ridx_reg <= cnt_reg[IW-1:0];
                    if (cnt_reg <= LAST)
                        cnt_reg <= cnt_reg + CW'(1);
                    if (q_reg.operation == rte_pkg::OP_REMOVE && rm_hit)
                        valid_reg[ridx_reg] <= 1'b0;
                    if (rv_reg && ridx_reg == LAST[IW-1:0])
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (do_add)
                        valid_reg[free_reg] <= 1'b1;
                    state_reg <= S_OUT;
                end
                default:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // scan accumulators (payload, cleared at acceptance)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            q_reg       <= req.data;
            exists_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
            best_ok_reg <= 1'b0;
            dflt_ok_reg <= 1'b0;
            score_reg   <= 32'd0;
        end
        else if (state_reg == S_SCAN && rv_reg)
        begin
            if (dup)
                exists_reg <= 1'b1;
            if (!valid_reg[ridx_reg] && !free_ok_reg)
            begin
                free_ok_reg <= 1'b1;
                free_reg    <= ridx_reg;
            end
            if (ll_hit || s_win)
            begin
                best_ok_reg <= 1'b1;
                best_reg    <= rd_q;
                bmask_reg   <= rd_q.mask;
                score_reg   <= ll_hit ? llmatch_reg : s;
            end
            if (dflt_hit)
            begin
                dflt_ok_reg <= 1'b1;
                dflt_reg    <= rd_q;
            end
        end
    end

endmodule

FILE: rtl/rte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rte_checker: port-level checks of the route table engine
// Watches the handshakes at the top level and flags protocol slips.
// ----------------------------------------------------------------------------
module rte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input rte_pkg::rsp_word_t rsp_data
);

    // a request is followed by a busy period, not another acceptance
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    // with no response pending, none shows up right after an acceptance
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
        else $error("response too early");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled response changed");

    // gateway or mask data never comes with status exists or nomem
    a_rsp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == rte_pkg::ST_EXISTS
                    || rsp_data.status == rte_pkg::ST_NOMEM))
        |-> (rsp_data.out_gateway_address == 32'd0 && rsp_data.out_subnet_mask == 32'd0))
        else $error("add status carries route data");

endmodule

bind ipv4_route_table_engine rte_checker u_rte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
